@@ hdl/wks_pkg.sv @@
// Shared types and constants for the weighted KS distance engine.
`timescale 1ns / 1ps

package wks_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int POS_W       = 32;
  localparam int WT_W        = 24;
  localparam int DIST_W      = WT_W + 1;
  // running sum of up to MAX_SAMPLES weights
  localparam int SUM_W       = WT_W + IDX_W + 1;
  localparam int OP_W        = 2;

  localparam int IN_FIELDS_W = IDX_W + POS_W + WT_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((DIST_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [SUM_W-1:0] ONE_Q24 = SUM_W'(1) << WT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_REF = 2'd0,
    OP_WRITE_TRL = 2'd1,
    OP_COMPUTE   = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_REF_COUNT = 1'b0,
    REG_TRL_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic        [WT_W-1:0]  wt;
  } sample_t;

  // zero counts as one, anything past the store depth saturates
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = CNT_W'(c);
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (CNT_W'(c) > MAX_CNT) begin
      r = MAX_CNT;
    end
    return r;
  endfunction

endpackage

@@ hdl/weighted_ks_distance.sv @@
// Top level: weighted two-sample KS distance engine with sample stores.
`timescale 1ns / 1ps

// Channel    Dir  Signals                         Contents
// in_        in   tvalid/tready/tdata/tuser       tuser: operation; tdata: slot, position, weight
// out_       out  tvalid/tready/tdata             tdata: distance (Q1.24, saturated at one)
// cfg_       in   we/addr/wdata                   0 reference_count, 1 trial_count
//
// A sample write or other transfer is taken every cycle while idle.
// A compute runs a select step, then the lead and trial/reference steps, then
// a drain: one shared adder advances one running sum per cycle, fed
// by one registered read port on each store.
// in_tready stays low during a compute; the result sits in an output register,
// and a finished walk waits only if that register still holds an untaken result.
// Reset (rst_n, synchronous) clears control state only; store contents are
// undefined until written.

module weighted_ks_distance
  import wks_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] slot, [41:10] position, [65:42] weight
  input  logic [OP_W-1:0]       in_tuser,   // [1:0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [24:0] distance
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SELECT = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_DRAIN  = 4'b1000
  } state_t;

  // -------------------------------------------------------------- input fields
  logic [IDX_W-1:0]        in_slot;
  logic signed [POS_W-1:0] in_pos;
  logic [WT_W-1:0]         in_wt;
  op_t                     in_op;
  logic                    in_xfer;

  assign in_slot = in_tdata[IDX_W-1:0];
  assign in_pos  = in_tdata[IDX_W+POS_W-1:IDX_W];
  assign in_wt   = in_tdata[IN_FIELDS_W-1:IDX_W+POS_W];
  assign in_op   = op_t'(in_tuser);

  // -------------------------------------------------------------- registers
  state_t state_r, state_nxt;
  logic [CFG_DATA_W-1:0] ref_cnt_r, trl_cnt_r;
  logic [CNT_W-1:0] lead_n_r, lead_n_nxt, other_n_r, other_n_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             lead_ref_r, lead_ref_nxt;   // reference set leads
  logic [SUM_W-1:0] sum_lead_r, sum_lead_nxt, sum_other_r, sum_other_nxt;
  logic [SUM_W-1:0] best_r, best_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  // -------------------------------------------------------------- stores
  sample_t ref_mem [MAX_SAMPLES];
  sample_t trl_mem [MAX_SAMPLES];
  sample_t ref_rd_r, trl_rd_r;
  logic [IDX_W-1:0] ref_addr, trl_addr;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_xfer && in_op == OP_WRITE_REF) begin
      ref_mem[in_slot] <= '{pos: in_pos, wt: in_wt};
    end
    if (in_xfer && in_op == OP_WRITE_TRL) begin
      trl_mem[in_slot] <= '{pos: in_pos, wt: in_wt};
    end
    ref_rd_r <= ref_mem[ref_addr];
    trl_rd_r <= trl_mem[trl_addr];
  end

  // lead/other views of the read data
  sample_t lead_d, other_d;
  assign lead_d  = lead_ref_r ? ref_rd_r : trl_rd_r;
  assign other_d = lead_ref_r ? trl_rd_r : ref_rd_r;

  // read addresses follow the next walk indices; wrap at full count is harmless
  always_comb begin
    if (lead_ref_nxt) begin
      ref_addr = i_nxt[IDX_W-1:0];
      trl_addr = j_nxt[IDX_W-1:0];
    end else begin
      ref_addr = j_nxt[IDX_W-1:0];
      trl_addr = i_nxt[IDX_W-1:0];
    end
  end

  // -------------------------------------------------------------- walk control
  logic take_other;   // other-set sample lies below the current lead sample
  logic lead_step;
  logic add_en;
  logic [SUM_W-1:0] add_a, add_b, add_y;
  logic [SUM_W-1:0] gap;

  assign take_other = (j_r < other_n_r) && (other_d.pos < lead_d.pos);

  // shared accumulator adder
  assign add_a = lead_step ? sum_lead_r : sum_other_r;
  assign add_b = lead_step ? SUM_W'(lead_d.wt) : SUM_W'(other_d.wt);
  assign add_y = add_a + add_b;

  // gap check looks at the registered sums, so every sum pair is seen
  assign gap = (sum_lead_r > sum_other_r) ? (sum_lead_r - sum_other_r)
                                          : (sum_other_r - sum_lead_r);

  always_comb begin
    state_nxt     = state_r;
    lead_n_nxt    = lead_n_r;
    other_n_nxt   = other_n_r;
    i_nxt         = '0;
    j_nxt         = '0;
    lead_ref_nxt  = lead_ref_r;
    sum_lead_nxt  = sum_lead_r;
    sum_other_nxt = sum_other_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_tready;
    dist_nxt      = dist_r;
    lead_step     = 1'b0;
    add_en        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_op == OP_COMPUTE) begin
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        // both stores now show entry zero; strictly smaller first position leads
        lead_ref_nxt  = (ref_rd_r.pos < trl_rd_r.pos);
        lead_n_nxt    = lead_ref_nxt ? clamp_count(ref_cnt_r) : clamp_count(trl_cnt_r);
        other_n_nxt   = lead_ref_nxt ? clamp_count(trl_cnt_r) : clamp_count(ref_cnt_r);
        sum_lead_nxt  = lead_ref_nxt ? SUM_W'(ref_rd_r.wt) : SUM_W'(trl_rd_r.wt);
        sum_other_nxt = '0;
        best_nxt      = '0;
        i_nxt         = CNT_W'(1);
        state_nxt     = ST_WALK;
      end
      ST_WALK: begin
        best_nxt = (gap > best_r) ? gap : best_r;
        i_nxt    = i_r;
        j_nxt    = j_r;
        if (i_r >= lead_n_r) begin
          state_nxt = ST_DRAIN;
        end else if (take_other) begin
          add_en        = 1'b1;
          sum_other_nxt = add_y;
          j_nxt         = j_r + CNT_W'(1);
        end else begin
          lead_step    = 1'b1;
          add_en       = 1'b1;
          sum_lead_nxt = add_y;
          i_nxt        = i_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          dist_nxt      = (best_r > ONE_Q24) ? DIST_W'(ONE_Q24) : best_r[DIST_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ref_cnt_r   <= CFG_DATA_W'(1);
      trl_cnt_r   <= CFG_DATA_W'(1);
      i_r         <= '0;
      j_r         <= '0;
      lead_ref_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      lead_ref_r  <= lead_ref_nxt;
      if (cfg_we && cfg_addr == REG_REF_COUNT) begin
        ref_cnt_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == REG_TRL_COUNT) begin
        trl_cnt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lead_n_r    <= lead_n_nxt;
    other_n_r   <= other_n_nxt;
    sum_lead_r  <= sum_lead_nxt;
    sum_other_r <= sum_other_nxt;
    best_r      <= best_nxt;
    dist_r      <= dist_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(dist_r);

`ifndef SYNTHESIS
  // other-set index never runs past its bound
  a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (j_r <= other_n_r))
    else $error("other index past bound");

  // lead index stops at the lead count
  a_i_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (i_r <= lead_n_r))
    else $error("lead index past bound");

  // the adder only fires inside the walk
  a_add_walk: assert property (@(posedge clk) disable iff (!rst_n)
    add_en |-> (state_r == ST_WALK))
    else $error("accumulator used outside walk");

  // leaving drain always posts a result
  a_drain_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && (!out_valid_r || out_tready)) |=> out_valid_r)
    else $error("walk finished without result");
`endif

endmodule

@@ sim/wks_checker.sv @@
// Checker for the weighted KS distance engine: tracks stores and counts, predicts, compares.
`timescale 1ns / 1ps

module wks_checker
  import wks_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam longint unsigned UNIT_Q24 = 64'd1 << WT_W;

  sample_t               ref_set [MAX_SAMPLES];
  sample_t               trl_set [MAX_SAMPLES];
  logic [CFG_DATA_W-1:0] ref_count_reg;
  logic [CFG_DATA_W-1:0] trl_count_reg;
  logic [DIST_W-1:0]     dist_q [$];
  int                    fails;

  initial begin
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      ref_set[k] = '0;
      trl_set[k] = '0;
    end
    ref_count_reg = 1;
    trl_count_reg = 1;
    fails         = 0;
  end

  // zero reads as one, past the depth saturates
  function automatic int span_of(input logic [CFG_DATA_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_SAMPLES) return MAX_SAMPLES;
    return int'(raw);
  endfunction

  function automatic sample_t sample_at(input bit from_trial, input int k);
    return from_trial ? trl_set[k] : ref_set[k];
  endfunction

  function automatic longint unsigned abs_diff(input longint unsigned a, b);
    return (a > b) ? a - b : b - a;
  endfunction

  // merge walk over both sorted sets, largest running-sum gap, clipped at one
  function automatic logic [DIST_W-1:0] ks_distance();
    int              lead_n;
    int              other_n;
    int              j;
    bit              trial_leads;
    longint unsigned lead_sum;
    longint unsigned other_sum;
    longint unsigned best;
    sample_t         lead_s;
    sample_t         other_s;
    trial_leads = !($signed(ref_set[0].pos) < $signed(trl_set[0].pos));
    lead_n      = trial_leads ? span_of(trl_count_reg) : span_of(ref_count_reg);
    other_n     = trial_leads ? span_of(ref_count_reg) : span_of(trl_count_reg);
    lead_s      = sample_at(trial_leads, 0);
    lead_sum    = lead_s.wt;
    other_sum   = 0;
    best        = lead_sum;
    j           = 0;
    for (int i = 1; i < lead_n; i++) begin
      lead_s = sample_at(trial_leads, i);
      while (j < other_n) begin
        other_s = sample_at(!trial_leads, j);
        if (!($signed(other_s.pos) < $signed(lead_s.pos))) break;
        other_sum += other_s.wt;
        if (abs_diff(lead_sum, other_sum) > best) best = abs_diff(lead_sum, other_sum);
        j++;
      end
      lead_sum += lead_s.wt;
      if (abs_diff(lead_sum, other_sum) > best) best = abs_diff(lead_sum, other_sum);
    end
    if (best > UNIT_Q24) best = UNIT_Q24;
    return best[DIST_W-1:0];
  endfunction

  always @(posedge clk) begin : observe
    sample_t           incoming;
    logic [DIST_W-1:0] want;
    if (!rst_n) begin
      ref_count_reg = 1;
      trl_count_reg = 1;
      dist_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_REF_COUNT: ref_count_reg = cfg_wdata;
          REG_TRL_COUNT: trl_count_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (dist_q.size() == 0) begin
          $display("%0t distance with none expected: expected none, actual %h",
                   $time, out_tdata[DIST_W-1:0]);
          fails++;
        end else begin
          want = dist_q.pop_front();
          if (out_tdata[DIST_W-1:0] !== want) begin
            $display("%0t distance mismatch: expected %h, actual %h",
                     $time, want, out_tdata[DIST_W-1:0]);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        incoming.pos = in_tdata[IDX_W +: POS_W];
        incoming.wt  = in_tdata[IDX_W+POS_W +: WT_W];
        case (op_t'(in_tuser))
          OP_WRITE_REF: ref_set[in_tdata[IDX_W-1:0]] = incoming;
          OP_WRITE_TRL: trl_set[in_tdata[IDX_W-1:0]] = incoming;
          OP_COMPUTE:   dist_q.push_back(ks_distance());
          default: ;
        endcase
      end
    end
    pending    <= dist_q.size();
    fail_count <= fails;
  end

endmodule

@@ sim/weighted_ks_distance_tb.sv @@
// Testbench top: stimulus, flow control and verdict for the weighted KS distance engine.
`timescale 1ns / 1ps

module weighted_ks_distance_tb;
  import wks_pkg::*;

  // Slowest legal stretch without a transfer: a full-depth compute sitting
  // behind the long receiver hold-off, plus bursts. Taken several times over.
  localparam int STALL_LIMIT  = 20000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int TRL_FILL     = 256;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;   // [9:0] slot, [41:10] position, [65:42] weight
  logic [OP_W-1:0]       in_tuser  = '0;   // [1:0] operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [24:0] distance
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int open_results;

  // which slots have been written since time zero; computes only ever
  // cover written prefixes since store contents are undefined until written
  bit ref_written [MAX_SAMPLES];
  bit trl_written [MAX_SAMPLES];

  int items_sent  = 0;
  int hold_asked  = 0;
  bit holding     = 1'b0;
  bit quiet_tail  = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  weighted_ks_distance u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  wks_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (open_results)
  );

  // ---------------------------------------------------------------------------
  // Input side. Fields go out at the rising edge; the transfer is seen on the
  // next edge where in_tready (pre-edge value) is high. Random gaps between
  // items, none once the quiet tail begins.
  // ---------------------------------------------------------------------------
  task automatic send_item(input op_t op, input logic [IDX_W-1:0] slot,
                           input logic [POS_W-1:0] pos, input logic [WT_W-1:0] wt);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({wt, pos, slot});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (op == OP_WRITE_REF) ref_written[slot] = 1'b1;
    if (op == OP_WRITE_TRL) trl_written[slot] = 1'b1;
  endtask

  // compute and unknown operations carry don't-care fields
  task automatic send_bare(input op_t op);
    send_item(op, IDX_W'($urandom), POS_W'($urandom), WT_W'($urandom));
  endtask

  // block idle: every expected distance taken, then a drain wait so that a
  // trailing sample write can land
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_counts(input logic [CFG_DATA_W-1:0] ref_raw,
                              input logic [CFG_DATA_W-1:0] trl_raw);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_REF_COUNT;
    cfg_wdata <= ref_raw;
    @(posedge clk);
    cfg_addr  <= REG_TRL_COUNT;
    cfg_wdata <= trl_raw;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int span_of(input logic [CFG_DATA_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_SAMPLES) return MAX_SAMPLES;
    return int'(raw);
  endfunction

  function automatic bit prefixes_written(input int n_ref, input int n_trl);
    for (int k = 0; k < n_ref; k++) if (!ref_written[k]) return 1'b0;
    for (int k = 0; k < n_trl; k++) if (!trl_written[k]) return 1'b0;
    return 1'b1;
  endfunction

  // mostly short sets, now and then a longer one; zero exercises the
  // zero-reads-as-one rule
  function automatic logic [CFG_DATA_W-1:0] pick_count();
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'($urandom_range(25, 80));
    return CFG_DATA_W'($urandom_range(0, 24));
  endfunction

  // position styles: 0 narrow (heavy ties), 1 wide, 2 pinned to the extremes
  function automatic longint first_pos(input int style);
    case (style)
      0:       return longint'($urandom_range(0, 6)) - 3;
      1:       return longint'($signed($urandom)) >>> 2;
      default: return -64'sd2147483648 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic longint step_pos(input longint p, input int style);
    longint n;
    case (style)
      0:       n = p + $urandom_range(0, 2);
      1:       n = p + $urandom_range(0, 1 << 20);
      default: n = p + $urandom_range(0, 32'h7FFF_FFFF);
    endcase
    if (n > 64'sd2147483647) n = 64'sd2147483647;
    return n;
  endfunction

  // weight styles: 0 random, 1 all max (saturation), 2 tiny, 3 zero or random
  function automatic logic [WT_W-1:0] next_weight(input int style);
    case (style)
      0:       return WT_W'($urandom);
      1:       return '1;
      2:       return WT_W'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? '0 : WT_W'($urandom);
    endcase
  endfunction

  // One setting of the counts: sorted sets with random content, laced with
  // noise (unknown operations, stray writes, early computes), then a few
  // computes. With squeeze set the receiver holds off while they go in.
  task automatic random_phase(input bit squeeze);
    logic [CFG_DATA_W-1:0] ref_raw;
    logic [CFG_DATA_W-1:0] trl_raw;
    int     n_ref;
    int     n_trl;
    int     ri;
    int     ti;
    int     pos_style;
    int     wt_style;
    longint ref_pos;
    longint trl_pos;
    ref_raw   = pick_count();
    trl_raw   = pick_count();
    wait_idle();
    write_counts(ref_raw, trl_raw);
    n_ref     = span_of(ref_raw);
    n_trl     = span_of(trl_raw);
    pos_style = $urandom_range(0, 2);
    wt_style  = $urandom_range(0, 3);
    ref_pos   = first_pos(pos_style);
    trl_pos   = first_pos(pos_style);
    ri        = 0;
    ti        = 0;
    while (ri < n_ref || ti < n_trl) begin
      case ($urandom_range(0, 19))
        0: send_bare(OP_NONE);
        1: send_item($urandom_range(0, 1) ? OP_WRITE_TRL : OP_WRITE_REF,
                     IDX_W'($urandom), POS_W'($urandom), WT_W'($urandom));
        2: if (prefixes_written(n_ref, n_trl)) send_bare(OP_COMPUTE);
        default: begin
          if (ti >= n_trl || (ri < n_ref && $urandom_range(0, 1) == 1)) begin
            send_item(OP_WRITE_REF, IDX_W'(ri), POS_W'(ref_pos), next_weight(wt_style));
            ref_pos = step_pos(ref_pos, pos_style);
            ri++;
          end else begin
            send_item(OP_WRITE_TRL, IDX_W'(ti), POS_W'(trl_pos), next_weight(wt_style));
            trl_pos = step_pos(trl_pos, pos_style);
            ti++;
          end
        end
      endcase
    end
    if (squeeze) begin
      // park the input until the hold-off has started
      in_tvalid <= 1'b0;
      hold_asked++;
      while (!holding) @(posedge clk);
    end
    repeat ($urandom_range(1, 3) + (squeeze ? 4 : 0)) send_bare(OP_COMPUTE);
  endtask

  // Fill the reference store to the full depth once (every slot bit toggles)
  // and the first part of the trial store, then walk with saturating and
  // one-sided counts.
  task automatic full_depth_phase();
    longint ref_pos;
    longint trl_pos;
    wait_idle();
    write_counts(CFG_DATA_W'(2047), CFG_DATA_W'(TRL_FILL));
    ref_pos = first_pos(1);
    trl_pos = first_pos(1);
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      send_item(OP_WRITE_REF, IDX_W'(k), POS_W'(ref_pos), next_weight(2));
      ref_pos = step_pos(ref_pos, 1);
      if (k < TRL_FILL) begin
        send_item(OP_WRITE_TRL, IDX_W'(k), POS_W'(trl_pos), next_weight(2));
        trl_pos = step_pos(trl_pos, 1);
      end
    end
    send_bare(OP_COMPUTE);
    wait_idle();
    write_counts(CFG_DATA_W'(MAX_SAMPLES), CFG_DATA_W'(1));
    send_bare(OP_COMPUTE);
    wait_idle();
    write_counts(CFG_DATA_W'(1), CFG_DATA_W'(TRL_FILL));
    send_bare(OP_COMPUTE);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure bursts, plus one long hold-off on request
  // so that a finished walk backs up and in_tready drops.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold_done;
    hold_done = 0;
    @(posedge clk);
    forever begin
      if (hold_asked != hold_done) begin
        hold_done++;
        holding = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (quiet_tail ? 1 : $urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Watchdog: any stretch this long without a transfer on a channel ends the run.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int phase_no;
    int stop_at;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Counts at their reset value of one. Reference at the most negative
    // position leads with full weight; trial at the top carries nothing.
    send_item(OP_WRITE_REF, '0, 32'h8000_0000, '1);
    send_item(OP_WRITE_TRL, '0, 32'h7FFF_FFFF, '0);
    send_bare(OP_COMPUTE);
    send_item(OP_NONE, '1, '1, '1);
    // equal first positions: trial set leads
    send_item(OP_WRITE_TRL, '0, 32'h8000_0000, WT_W'(1));
    send_bare(OP_COMPUTE);

    // zero count reads as one; trial leads on the tie and the reference
    // sample slots in before the trial's second one
    wait_idle();
    write_counts('0, CFG_DATA_W'(2));
    send_item(OP_WRITE_TRL, IDX_W'(1), '0, '1);
    send_bare(OP_COMPUTE);

    // interleaved sets, all weight on the reference side: gap clips at one
    wait_idle();
    write_counts(CFG_DATA_W'(3), CFG_DATA_W'(3));
    for (int k = 0; k < 3; k++) begin
      send_item(OP_WRITE_REF, IDX_W'(k), POS_W'(2 * k), '1);
      send_item(OP_WRITE_TRL, IDX_W'(k), POS_W'(2 * k + 1), '0);
    end
    send_bare(OP_COMPUTE);
    send_item(OP_NONE, '0, '0, '0);

    phase_no = 0;
    while (items_sent < 180 || phase_no < 3) begin
      random_phase(phase_no == 2);
      phase_no++;
    end
    full_depth_phase();

    // closing stretch runs with both sides flat out
    quiet_tail = 1'b1;
    stop_at    = items_sent + 450;
    while (items_sent < stop_at) random_phase(1'b0);
    wait_idle();

    if (fail_count == 0 && open_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/wks_pkg.sv
hdl/weighted_ks_distance.sv
sim/wks_checker.sv
sim/weighted_ks_distance_tb.sv
